FILE: hdl/lpf_pkg.sv
// ---------------------------------------------------------------------------
// lpf_pkg
// shared types and codes for the link provisioning fallback mode controller
// ---------------------------------------------------------------------------
package lpf_pkg;

  localparam int unsigned TimeW = 32;

  typedef enum logic [1:0] {
    MODE_PORTAL     = 2'd0,
    MODE_CONNECTING = 2'd1,
    MODE_CONNECTED  = 2'd2
  } mode_e;

  typedef enum logic [2:0] {
    ACT_NONE   = 3'd0,
    ACT_PORTAL = 3'd1,
    ACT_START  = 3'd2,
    ACT_RETRY  = 3'd3,
    ACT_LINKED = 3'd4
  } action_e;

  typedef enum logic {
    CMD_BEGIN  = 1'b0,
    CMD_UPDATE = 1'b1
  } command_e;

  typedef enum logic {
    REG_GRACE = 1'b0,
    REG_RETRY = 1'b1
  } reg_idx_e;

  // one input word after unpacking
  typedef struct packed {
    command_e         command;
    logic [TimeW-1:0] now_ms;
    logic             has_saved_credentials;
    logic             manual_setup;
    logic             link_up;
    logic             portal_active;
  } item_t;

  // controller state carried between words
  typedef struct packed {
    mode_e            mode;
    logic             link_was_up;
    logic [TimeW-1:0] connect_start_time;
    logic [TimeW-1:0] last_retry_time;
  } state_t;

  // timing registers
  typedef struct packed {
    logic [TimeW-1:0] grace_period_ms;
    logic [TimeW-1:0] retry_interval_ms;
  } timing_t;

endpackage

FILE: hdl/lpf_step.sv
// ---------------------------------------------------------------------------
// lpf_step
// next-state and action decision for one word
// ---------------------------------------------------------------------------
module lpf_step
  import lpf_pkg::*;
(
  input  item_t   item_i,
  input  state_t  state_i,
  input  timing_t timing_i,
  output state_t  state_o,
  output action_e action_o
);

  logic [TimeW-1:0] since_start;
  logic [TimeW-1:0] since_retry;

  // wrapping elapsed times
  assign since_start = item_i.now_ms - state_i.connect_start_time;
  assign since_retry = item_i.now_ms - state_i.last_retry_time;

  always_comb begin
    state_o  = state_i;
    action_o = ACT_NONE;
    if (item_i.command == CMD_BEGIN) begin
      state_o.link_was_up = 1'b0;
      if (item_i.manual_setup || !item_i.has_saved_credentials) begin
        state_o.mode = MODE_PORTAL;
        action_o     = ACT_PORTAL;
      end else begin
        state_o.mode               = MODE_CONNECTING;
        state_o.connect_start_time = item_i.now_ms;
        state_o.last_retry_time    = item_i.now_ms;
        action_o                   = ACT_START;
      end
    end else if (state_i.mode == MODE_PORTAL) begin
      if (!item_i.portal_active) begin
        state_o.link_was_up = item_i.link_up;
        if (item_i.link_up) begin
          state_o.mode = MODE_CONNECTED;
          action_o     = ACT_LINKED;
        end else begin
          state_o.mode               = MODE_CONNECTING;
          state_o.connect_start_time = item_i.now_ms;
          state_o.last_retry_time    = item_i.now_ms;
          action_o                   = ACT_START;
        end
      end
    end else if (item_i.manual_setup) begin
      state_o.mode = MODE_PORTAL;
      action_o     = ACT_PORTAL;
    end else if (item_i.link_up) begin
      state_o.link_was_up = 1'b1;
      state_o.mode        = MODE_CONNECTED;
      if ((state_i.mode != MODE_CONNECTED) || !state_i.link_was_up) begin
        action_o = ACT_LINKED;
      end
    end else if ((state_i.mode == MODE_CONNECTED) || state_i.link_was_up) begin
      // link dropped: restart connection
      state_o.link_was_up        = 1'b0;
      state_o.mode               = MODE_CONNECTING;
      state_o.connect_start_time = item_i.now_ms;
      state_o.last_retry_time    = item_i.now_ms;
      action_o                   = ACT_START;
    end else begin
      state_o.link_was_up = 1'b0;
      if (since_start >= timing_i.grace_period_ms) begin
        state_o.mode = MODE_PORTAL;
        action_o     = ACT_PORTAL;
      end else if (since_retry >= timing_i.retry_interval_ms) begin
        state_o.last_retry_time = item_i.now_ms;
        action_o                = ACT_RETRY;
      end
    end
  end

endmodule

FILE: hdl/link_provisioning_fallback_fsm_unit.sv
// ---------------------------------------------------------------------------
// link_provisioning_fallback_fsm_unit
// wireless link bring-up mode controller with grace timeout fallback
// ---------------------------------------------------------------------------
// Each input word (a begin or update command with a millisecond timestamp and
// status flags) yields exactly one output word holding an action code and the
// mode after the step. A word is taken into an input register, decided by one
// pass of logic (two 32-bit wrapping subtracts and compares) and lands in the
// output register together with the state update; the block sustains one word
// per cycle unless m_axis_tready_i stalls it. The output register and the
// input register together let a new word be accepted while a result still
// waits on m_axis_tready_i. The user must write the timing registers through
// cfg_we_i/cfg_idx_i/cfg_data_i while the block is idle, which is not enforced.
module link_provisioning_fallback_fsm_unit
  import lpf_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  // configuration writes
  input  logic             cfg_we_i,
  input  logic             cfg_idx_i,
  input  logic [TimeW-1:0] cfg_data_i,
  // input words
  input  logic             s_axis_tvalid_i,
  output logic             s_axis_tready_o,
  // [31:0] now_ms, [32] has_saved_credentials, [33] manual_setup,
  // [34] link_up, [35] portal_active, [39:36] zero
  input  logic [39:0]      s_axis_tdata_i,
  // [0] command
  input  logic             s_axis_tuser_i,
  // output words
  output logic             m_axis_tvalid_o,
  input  logic             m_axis_tready_i,
  // [2:0] action, [4:3] mode_now, [7:5] zero
  output logic [7:0]       m_axis_tdata_o
);

  // timing registers
  timing_t timing_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      timing_q.grace_period_ms   <= TimeW'(30000);
      timing_q.retry_interval_ms <= TimeW'(5000);
    end else if (cfg_we_i) begin
      unique case (reg_idx_e'(cfg_idx_i))
        REG_GRACE: timing_q.grace_period_ms   <= cfg_data_i;
        REG_RETRY: timing_q.retry_interval_ms <= cfg_data_i;
        default:   ;
      endcase
    end
  end

  // input register
  logic  in_valid_q;
  item_t in_item_q;
  logic  out_valid_q;
  logic  out_free;
  logic  advance;

  // output slot is free when empty or being drained this cycle
  assign out_free        = !out_valid_q || m_axis_tready_i;
  assign advance         = in_valid_q && out_free;
  assign s_axis_tready_o = !in_valid_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready_o) begin
      in_valid_q <= s_axis_tvalid_i;
    end
  end

  // payload holds while the stage is stalled
  always_ff @(posedge clk_i) begin
    if (s_axis_tready_o && s_axis_tvalid_i) begin
      in_item_q.command               <= command_e'(s_axis_tuser_i);
      in_item_q.now_ms                <= s_axis_tdata_i[31:0];
      in_item_q.has_saved_credentials <= s_axis_tdata_i[32];
      in_item_q.manual_setup          <= s_axis_tdata_i[33];
      in_item_q.link_up               <= s_axis_tdata_i[34];
      in_item_q.portal_active         <= s_axis_tdata_i[35];
    end
  end

  // decision logic against the current state
  state_t  state_q;
  state_t  state_d;
  action_e action_d;

  lpf_step u_step (
    .item_i   (in_item_q),
    .state_i  (state_q),
    .timing_i (timing_q),
    .state_o  (state_d),
    .action_o (action_d)
  );

  // state commits when the word moves to the output register,
  // so the next word in the input register sees it straight away
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q.mode               <= MODE_PORTAL;
      state_q.link_was_up        <= 1'b0;
      state_q.connect_start_time <= '0;
      state_q.last_retry_time    <= '0;
    end else if (advance) begin
      state_q <= state_d;
    end
  end

  // output register
  action_e out_action_q;
  mode_e   out_mode_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_free) begin
      out_valid_q <= in_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_action_q <= action_d;
      out_mode_q   <= state_d.mode;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {3'b000, out_mode_q, out_action_q};

endmodule

FILE: hdl/lpf_checker.sv
// ---------------------------------------------------------------------------
// lpf_checker
// port-level checks on the mode controller output words
// ---------------------------------------------------------------------------
module lpf_checker
  import lpf_pkg::*;
(
  input logic       clk_i,
  input logic       rst_ni,
  input logic       m_tvalid_i,
  input logic       m_tready_i,
  input logic [7:0] m_tdata_i
);

  logic [2:0] act;
  logic [1:0] mode;

  assign act  = m_tdata_i[2:0];
  assign mode = m_tdata_i[4:3];

  // a stalled output word holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_tvalid_i && !m_tready_i |=> m_tvalid_i && $stable(m_tdata_i))
    else $error("output word changed while stalled");

  // start and retry leave the block connecting
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_tvalid_i && (act == ACT_START || act == ACT_RETRY) |-> mode == MODE_CONNECTING)
    else $error("connection action without connecting mode");

  // portal action always lands in portal mode
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_tvalid_i && act == ACT_PORTAL |-> mode == MODE_PORTAL)
    else $error("portal action without portal mode");

  // connected action always lands in connected mode
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_tvalid_i && act == ACT_LINKED |-> mode == MODE_CONNECTED)
    else $error("connected action without connected mode");

endmodule

bind link_provisioning_fallback_fsm_unit lpf_checker u_lpf_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .m_tvalid_i (m_axis_tvalid_o),
  .m_tready_i (m_axis_tready_i),
  .m_tdata_i  (m_axis_tdata_o)
);
